>>> hdl/afs_pkg.sv
`timescale 1ns / 1ps

package afs_pkg;

	// default sizes
	localparam int DEF_MAX_ANIMATIONS = 64;
	localparam int DEF_MAX_FRAMES     = 256;

	// field limits
	localparam int INDEX_LIMIT       = 64;
	localparam int FRAME_FIELD_LIMIT = 256;
	localparam logic [13:0] DURATION_LIMIT = 14'd10000;
	localparam logic [21:0] TOTAL_MAX      = 22'h3FFFFF;
	localparam int TICK_W = 48;

	// request command codes
	localparam logic [1:0] CMD_DURATION = 2'd0;
	localparam logic [1:0] CMD_COUNT    = 2'd1;
	localparam logic [1:0] CMD_EVAL     = 2'd2;
	localparam logic [1:0] CMD_UNUSED   = 2'd3;

	// per animation record
	typedef struct packed {
		logic [8:0]  count;
		logic [21:0] total;
		logic [7:0]  shown;
	} meta_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_EV_RD,
		ST_EV_CHK,
		ST_DIV,
		ST_WALK_RD,
		ST_WALK_CMP,
		ST_DECIDE,
		ST_PUSH,
		ST_EV_NEXT,
		ST_FLUSH
	} state_t;

endpackage

>>> hdl/animation_frame_selector.sv
`timescale 1ns / 1ps

// channel   | handshake             | payload
// request   | in_valid / in_stall   | cmd, anim_index, frame_index, duration,
//           |                       | frame_count, tick_count
// result    | out_valid / out_stall | anim_index_res, new_frame, last
// config    | cfg_we                | cfg_wdata (animation_count)
//
// a load request reads the animation record, then writes it back; an
// evaluate request, per animation evaluated, reads and checks its record,
// runs the bit-serial modulo unit over the tick count, then walks the
// frames with one duration memory read per frame stepped past, stops on
// the last frame or a duration compare, and hands over any pending result;
// an empty animation is skipped after its check.
// reset clears control state and the per-animation valid bits at once, no
// clearing pass; durations are undefined until written.
// in_stall is high for the whole of a request; a stalled result holds the
// sequencer in its hand-over state.
module animation_frame_selector #(
	parameter int MAX_ANIMATIONS = afs_pkg::DEF_MAX_ANIMATIONS,
	parameter int MAX_FRAMES     = afs_pkg::DEF_MAX_FRAMES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [5:0]  anim_index,
	input  logic [7:0]  frame_index,
	input  logic [13:0] duration,
	input  logic [8:0]  frame_count,
	input  logic [47:0] tick_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  anim_index_res,
	output logic [7:0]  new_frame,
	output logic        last,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);
	import afs_pkg::*;

	localparam int ANIM_AW  = (MAX_ANIMATIONS > 1) ? $clog2(MAX_ANIMATIONS) : 1;
	localparam int FRAME_AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int DUR_DEPTH = 1 << (ANIM_AW + FRAME_AW);
	localparam int FRAME_LIM = (MAX_FRAMES < FRAME_FIELD_LIMIT) ? MAX_FRAMES
		: FRAME_FIELD_LIMIT;
	localparam int ANIM_LIM = (MAX_ANIMATIONS < INDEX_LIMIT) ? MAX_ANIMATIONS
		: INDEX_LIMIT;

	state_t state_q, state_d;

	// latched request
	logic [1:0]  cmd_q;
	logic [5:0]  anim_q;
	logic [7:0]  fi_q;
	logic [13:0] dur_in_q;
	logic [8:0]  fc_q;
	logic [47:0] tick_q;
	logic [6:0]  anim_count_q;

	// evaluation state
	logic [6:0]  i_q;
	logic [6:0]  lim_q;
	logic [5:0]  bit_q;
	logic [21:0] rest_q;
	logic [7:0]  f_q;
	meta_t       cur_q;

	// pending and output results
	logic       pend_valid_q;
	logic [5:0] pend_anim_q;
	logic [7:0] pend_frame_q;
	logic       out_valid_q;
	logic [5:0] out_anim_q;
	logic [7:0] out_frame_q;
	logic       out_last_q;

	// memories
	meta_t       meta_mem [MAX_ANIMATIONS];
	logic [MAX_ANIMATIONS-1:0] meta_vld_q;
	meta_t       meta_rd_q;
	logic [13:0] dur_mem [DUR_DEPTH];
	logic [13:0] dur_rd_q;

	logic [ANIM_AW-1:0]          meta_addr;
	logic [ANIM_AW+FRAME_AW-1:0] dur_addr;
	logic                        accept;
	logic                        anim_ok;
	logic [6:0]                  lim;
	logic                        out_free;
	logic [22:0]                 trial;
	logic [22:0]                 sum;
	logic                        frame_ok;
	logic                        walk_end;
	logic [8:0]                  fc_clamped;

	assign accept   = in_valid && !in_stall;
	assign anim_ok  = int'(anim_index) < MAX_ANIMATIONS;
	assign lim      = (anim_count_q > 7'(ANIM_LIM)) ? 7'(ANIM_LIM) : anim_count_q;
	assign out_free = !out_valid_q || !out_stall;
	assign trial    = {rest_q, tick_q[bit_q]};
	assign sum      = {1'b0, meta_rd_q.total} + {9'd0, dur_in_q};
	assign frame_ok = {1'b0, fi_q} < meta_rd_q.count;
	assign walk_end = ({1'b0, f_q} + 9'd1) >= cur_q.count;
	assign fc_clamped = (fc_q > 9'(FRAME_LIM)) ? 9'(FRAME_LIM) : fc_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_DURATION: if (anim_ok && duration != 14'd0
							&& duration <= DURATION_LIMIT) state_d = ST_LOAD_RD;
						CMD_COUNT: if (anim_ok) state_d = ST_LOAD_RD;
						CMD_EVAL: if (lim != 7'd0) state_d = ST_EV_RD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD_RD:  state_d = ST_LOAD_WR;
			ST_LOAD_WR:  state_d = ST_IDLE;
			ST_EV_RD:    state_d = ST_EV_CHK;
			ST_EV_CHK: begin
				if (meta_rd_q.count == 9'd0 || meta_rd_q.total == 22'd0)
					state_d = ST_EV_NEXT;
				else
					state_d = ST_DIV;
			end
			ST_DIV:      if (bit_q == 6'd0) state_d = ST_WALK_RD;
			ST_WALK_RD:  state_d = walk_end ? ST_DECIDE : ST_WALK_CMP;
			ST_WALK_CMP: begin
				if (rest_q < {8'd0, dur_rd_q}) state_d = ST_DECIDE;
				else state_d = ST_WALK_RD;
			end
			ST_DECIDE: begin
				if (f_q == cur_q.shown) state_d = ST_EV_NEXT;
				else if (pend_valid_q) state_d = ST_PUSH;
				else state_d = ST_EV_NEXT;
			end
			ST_PUSH:     if (out_free) state_d = ST_EV_NEXT;
			ST_EV_NEXT: begin
				if (i_q + 7'd1 >= lim_q)
					state_d = pend_valid_q ? ST_FLUSH : ST_IDLE;
				else
					state_d = ST_EV_RD;
			end
			ST_FLUSH:    if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs and memory addresses
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		meta_addr = (state_q == ST_LOAD_RD) ? ANIM_AW'(anim_q) : ANIM_AW'(i_q);
		dur_addr  = (state_q == ST_LOAD_WR) ? {ANIM_AW'(anim_q), FRAME_AW'(fi_q)}
			: {ANIM_AW'(i_q), FRAME_AW'(f_q)};
	end

	assign out_valid      = out_valid_q;
	assign anim_index_res = out_anim_q;
	assign new_frame      = out_frame_q;
	assign last           = out_last_q;

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			anim_count_q <= 7'd0;
			meta_vld_q   <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) anim_count_q <= cfg_wdata;
			// result register: load on hand-over, clear once taken
			if ((state_q == ST_PUSH || state_q == ST_FLUSH) && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_LOAD_WR: begin
					if (cmd_q == CMD_COUNT || frame_ok)
						meta_vld_q[ANIM_AW'(anim_q)] <= 1'b1;
				end
				ST_DECIDE: begin
					if (f_q != cur_q.shown) begin
						meta_vld_q[ANIM_AW'(i_q)] <= 1'b1;
						if (!pend_valid_q) pend_valid_q <= 1'b1;
					end
				end
				ST_FLUSH: begin
					if (out_free)
						pend_valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// datapath: request latch, modulo unit, walk, result hand-over
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			anim_q   <= anim_index;
			fi_q     <= frame_index;
			dur_in_q <= duration;
			fc_q     <= frame_count;
			tick_q   <= tick_count;
			lim_q    <= lim;
			i_q      <= 7'd0;
		end
		case (state_q)
			ST_EV_CHK: begin
				cur_q  <= meta_rd_q;
				rest_q <= 22'd0;
				bit_q  <= 6'(TICK_W - 1);
			end
			ST_DIV: begin
				// one quotient bit per cycle
				if (trial >= {1'b0, cur_q.total}) rest_q <= 22'(trial - {1'b0, cur_q.total});
				else rest_q <= trial[21:0];
				bit_q <= bit_q - 6'd1;
				f_q   <= 8'd0;
			end
			ST_WALK_CMP: begin
				if (rest_q >= {8'd0, dur_rd_q}) begin
					rest_q <= rest_q - {8'd0, dur_rd_q};
					f_q    <= f_q + 8'd1;
				end
			end
			ST_DECIDE: begin
				if (f_q != cur_q.shown && !pend_valid_q) begin
					pend_anim_q  <= i_q[5:0];
					pend_frame_q <= f_q;
				end
			end
			ST_PUSH: begin
				if (out_free) begin
					out_anim_q   <= pend_anim_q;
					out_frame_q  <= pend_frame_q;
					out_last_q   <= 1'b0;
					pend_anim_q  <= i_q[5:0];
					pend_frame_q <= f_q;
				end
			end
			ST_EV_NEXT: i_q <= i_q + 7'd1;
			ST_FLUSH: begin
				if (out_free) begin
					out_anim_q  <= pend_anim_q;
					out_frame_q <= pend_frame_q;
					out_last_q  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// per animation record memory
	always_ff @(posedge clk) begin
		meta_rd_q <= meta_vld_q[meta_addr] ? meta_mem[meta_addr] : '0;
		if (state_q == ST_LOAD_WR) begin
			if (cmd_q == CMD_COUNT)
				meta_mem[ANIM_AW'(anim_q)] <= '{count: fc_clamped, total: 22'd0,
					shown: meta_rd_q.shown};
			else if (frame_ok)
				meta_mem[ANIM_AW'(anim_q)] <= '{count: meta_rd_q.count,
					total: (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[21:0],
					shown: meta_rd_q.shown};
		end else if (state_q == ST_DECIDE && f_q != cur_q.shown) begin
			meta_mem[ANIM_AW'(i_q)] <= '{count: cur_q.count, total: cur_q.total,
				shown: f_q};
		end
	end

	// frame duration memory
	always_ff @(posedge clk) begin
		dur_rd_q <= dur_mem[dur_addr];
		if (state_q == ST_LOAD_WR && cmd_q == CMD_DURATION && frame_ok)
			dur_mem[dur_addr] <= dur_in_q;
	end

endmodule

>>> hdl/afs_checker.sv
`timescale 1ns / 1ps

module afs_checker #(
	parameter int MAX_ANIMATIONS = afs_pkg::DEF_MAX_ANIMATIONS
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  cmd,
	input logic [5:0]  anim_index,
	input logic        out_valid,
	input logic        out_stall,
	input logic [5:0]  anim_index_res,
	input logic [7:0]  new_frame,
	input logic        last
);
	import afs_pkg::*;

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(anim_index_res) && $stable(new_frame)
		&& $stable(last))
		else $error("result payload changed while stalled");

	// a frame count load keeps the block busy next cycle
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_COUNT
		&& int'(anim_index) < MAX_ANIMATIONS |=> in_stall)
		else $error("load request not processed");

	// an unknown command is dropped at once
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd != CMD_DURATION && cmd != CMD_COUNT
		&& cmd != CMD_EVAL |=> !in_stall)
		else $error("unknown command held the block");

endmodule

bind animation_frame_selector afs_checker #(.MAX_ANIMATIONS(MAX_ANIMATIONS)) u_afs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
	.anim_index(anim_index), .out_valid(out_valid), .out_stall(out_stall),
	.anim_index_res(anim_index_res), .new_frame(new_frame), .last(last)
);
